// ===== rtl/core/dcfc_pkg.sv =====
// Shared types, DES tables and permutation helpers for the DES-CBC file cipher.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
package dcfc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned REG_KEY      = 0;
  localparam int unsigned REG_PARITY   = 1;
  localparam int unsigned REG_DIR      = 2;
  localparam int unsigned REG_PAD      = 3;

  // One classified word waiting for the cipher engine.
  typedef struct packed {
    logic [63:0] blk;     // plaintext, padded where short or final, or raw ciphertext
    logic        fin;
    logic        start;
    logic        upd;     // chaining vector takes the ciphertext
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } bk_state_t;

  localparam byte unsigned IP_T [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam byte unsigned FP_T [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam byte unsigned E_T [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam byte unsigned P_T [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam byte unsigned PC1_T [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam byte unsigned PC2_T [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [1:0] ROT_T [16] = '{
    2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};
  localparam logic [3:0] SBOX_T [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] des_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-IP_T[i]];
    return r;
  endfunction

  function automatic logic [63:0] des_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64-FP_T[i]];
    return r;
  endfunction

  function automatic logic [55:0] des_pc1(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64-PC1_T[i]];
    return r;
  endfunction

  function automatic logic [47:0] des_pc2(input logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56-PC2_T[i]];
    return r;
  endfunction

  // One Feistel function: expansion, key mix, S-boxes, P permutation.
  function automatic logic [31:0] des_f(input logic [31:0] x, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] r;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = x[32-E_T[i]];
    e = e ^ k;
    for (int s = 0; s < 8; s++) begin
      six = e[47-6*s -: 6];
      o[31-4*s -: 4] = SBOX_T[s][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) r[31-i] = o[32-P_T[i]];
    return r;
  endfunction

  // Bit 7 of each byte is forced so that the byte has odd parity.
  function automatic logic [63:0] condition_key(input logic [63:0] k);
    logic [63:0] r;
    r = k;
    for (int i = 0; i < 8; i++) r[8*i+7] = ~^k[8*i +: 7];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [1:0] s);
    return (s == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
  endfunction

  function automatic logic [27:0] rotr28(input logic [27:0] x, input logic [1:0] s);
    return (s == 2'd2) ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
  endfunction

endpackage

// ===== rtl/core/des_cbc_file_cipher.sv =====
// Top level of the DES-CBC file cipher with length-byte padding.
// Depends on dcfc_pkg, dcfc_front, dcfc_queue and dcfc_back.
//
// Usage: each input word is one 64-bit block with its byte count, final and
// start flags. A word is taken at a clock edge where in_valid is high and
// in_stall is low; a result word leaves the same way on the out_ channel.
// The front pads a short or final encrypt block from the pad vector and
// writes the classified word into a small queue, so words keep arriving
// while the engine works and while a finished result waits to be taken.
// The engine runs one DES round per cycle over a shared round unit: a word
// passes through 16 rounds and then a finishing state that applies the final
// permutation and the chaining XOR. While busy, the engine takes the next word
// from the queue only in that finishing state, so it cannot start a word before
// the last one is through its rounds. An accepted word is taken from the queue,
// runs its rounds and the finish, and its result is then registered for out_.
// Configuration (key, parity rule, direction, pad vector) is written through
// cfg_we/cfg_index/cfg_data while the block is idle. Reset clears the
// registers, the chaining vector and the queue. When the receiver stalls,
// the result is held, the engine waits in its finishing cycle, and the
// queue fills until in_stall rises.
`timescale 1ns / 1ps
module des_cbc_file_cipher #(
  parameter int unsigned QUEUE_DEPTH = dcfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_block,
  input  logic [3:0]  in_byte_count,
  input  logic        in_final_block,
  input  logic        in_start_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_block,
  output logic [3:0]  out_valid_bytes,
  output logic        out_block_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import dcfc_pkg::*;

  logic [63:0] key_r, pad_r;
  logic        parity_r, dir_r;

  entry_t  fr_entry, q_entry;
  q_stat_t q_stat;
  logic    push, pop;

  // Configuration registers; all four indexes are defined.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      parity_r <= 1'b0;
      dir_r    <= 1'b0;
      pad_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(REG_KEY):    key_r    <= cfg_data;
        2'(REG_PARITY): parity_r <= cfg_data[0];
        2'(REG_DIR):    dir_r    <= cfg_data[0];
        2'(REG_PAD):    pad_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  dcfc_front u_front (
    .data_block  (in_data_block),
    .byte_count  (in_byte_count),
    .final_block (in_final_block),
    .start_file  (in_start_file),
    .dir         (dir_r),
    .pad_vector  (pad_r),
    .entry       (fr_entry)
  );

  dcfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (fr_entry),
    .pop      (pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  dcfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .key_value        (key_r),
    .preserve_parity  (parity_r),
    .dir              (dir_r),
    .entry            (q_entry),
    .q_empty          (q_stat.empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .out_valid_bytes  (out_valid_bytes),
    .out_block_error  (out_block_error)
  );

  // The engine never takes a word from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  // The queue status flags are never both set.
  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full)) else $error("queue both empty and full");

  // A full queue stays full until a word is taken; a word pushed into it would be lost.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !pop |=> q_stat.full) else $error("queue lost a word");

  // Encryption results always report a full block and no error.
  a_enc_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !dir_r |-> out_valid_bytes == 4'd8 && !out_block_error)
    else $error("bad encrypt status");

endmodule

// ===== rtl/core/dcfc_front.sv =====
// Front end: classifies an incoming word and pads a short or final encrypt block.
// Depends on dcfc_pkg.
`timescale 1ns / 1ps
module dcfc_front (
  input  logic [63:0]     data_block,
  input  logic [3:0]      byte_count,
  input  logic            final_block,
  input  logic            start_file,
  input  logic            dir,
  input  logic [63:0]     pad_vector,
  output dcfc_pkg::entry_t entry
);
  import dcfc_pkg::*;

  logic       pad;
  logic [2:0] n;
  logic [63:0] blk;
  logic [2:0] pidx;

  always_comb begin
    pad = !dir && (final_block || (byte_count < 4'd8));
    n   = (byte_count > 4'd7) ? 3'd7 : byte_count[2:0];
    for (int i = 0; i < 8; i++) begin
      pidx = 3'(i) - n;
      if (i == 7) blk[7:0] = {5'd0, n};
      else if (3'(i) < n) blk[63-8*i -: 8] = data_block[63-8*i -: 8];
      else blk[63-8*i -: 8] = pad_vector[63-8*pidx -: 8];
    end
    entry.blk   = pad ? blk : data_block;
    entry.fin   = final_block;
    entry.start = start_file;
    entry.upd   = !dir && !pad;
  end

endmodule

// ===== rtl/core/dcfc_queue.sv =====
// Short first-in first-out queue of classified words between front and engine.
// Depends on dcfc_pkg.
`timescale 1ns / 1ps
module dcfc_queue #(
  parameter int unsigned DEPTH = dcfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dcfc_pkg::entry_t  wr_entry,
  input  logic              pop,
  output dcfc_pkg::entry_t  rd_entry,
  output dcfc_pkg::q_stat_t stat
);
  import dcfc_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign rd_entry   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/dcfc_back.sv =====
// Cipher engine: one DES round per cycle, CBC chaining and the result register.
// Depends on dcfc_pkg.
`timescale 1ns / 1ps
module dcfc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [63:0]      key_value,
  input  logic             preserve_parity,
  input  logic             dir,
  input  dcfc_pkg::entry_t entry,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_result_block,
  output logic [3:0]       out_valid_bytes,
  output logic             out_block_error
);
  import dcfc_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [3:0]  rnd_r;
  logic [31:0] l_r, r_r;
  logic [55:0] cd_r;
  logic [63:0] cv_r, data_r;
  logic        fin_r, upd_r, dec_r;
  logic        out_valid_r;
  logic [63:0] res_r;
  logic [3:0]  vb_r;
  logic        err_r;

  logic        load_out, out_free;
  logic [55:0] cd_eff;
  logic [31:0] nr;
  logic [63:0] fp, res, cv_after, cv_cur, cv_eff, ip;
  logic [7:0]  cnt_byte;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_RUN;
      BK_RUN:  if (rnd_r == 4'd15) state_nxt = BK_FIN;
      BK_FIN:  if (out_free) state_nxt = q_empty ? BK_IDLE : BK_RUN;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_IDLE: pop = !q_empty;
      BK_FIN: begin
        load_out = out_free;
        pop      = out_free && !q_empty;
      end
      default: ;
    endcase
  end

  // Round datapath; decryption walks the key schedule backwards.
  always_comb begin
    if (!dec_r) begin
      cd_eff = {rotl28(cd_r[55:28], ROT_T[rnd_r]), rotl28(cd_r[27:0], ROT_T[rnd_r])};
    end else if (rnd_r == 4'd0) begin
      cd_eff = cd_r;
    end else begin
      cd_eff = {rotr28(cd_r[55:28], ROT_T[4'd0 - rnd_r]),
                rotr28(cd_r[27:0], ROT_T[4'd0 - rnd_r])};
    end
    nr = l_r ^ des_f(r_r, des_pc2(cd_eff));
  end

  // Finish, chaining update, and start of the next word in the same cycle.
  always_comb begin
    fp       = des_fp({r_r, l_r});
    res      = dec_r ? (fp ^ cv_r) : fp;
    cnt_byte = res[7:0];
    if (dec_r) cv_after = data_r;
    else if (upd_r) cv_after = res;
    else cv_after = cv_r;
    cv_cur = load_out ? cv_after : cv_r;
    cv_eff = entry.start ? 64'd0 : cv_cur;
    ip     = des_ip(dir ? entry.blk : (entry.blk ^ cv_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
      rnd_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) cv_r <= cv_eff;
      else if (load_out) cv_r <= cv_after;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (pop) rnd_r <= '0;
      else if (state_r == BK_RUN) rnd_r <= rnd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      l_r    <= ip[63:32];
      r_r    <= ip[31:0];
      cd_r   <= des_pc1(preserve_parity ? key_value : condition_key(key_value));
      data_r <= entry.blk;
      fin_r  <= entry.fin;
      upd_r  <= entry.upd;
      dec_r  <= dir;
    end else if (state_r == BK_RUN) begin
      l_r  <= r_r;
      r_r  <= nr;
      cd_r <= cd_eff;
    end
    if (load_out) begin
      res_r <= res;
      if (dec_r && fin_r) begin
        err_r <= (cnt_byte > 8'd7);
        vb_r  <= (cnt_byte > 8'd7) ? 4'd0 : cnt_byte[3:0];
      end else begin
        err_r <= 1'b0;
        vb_r  <= 4'd8;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = res_r;
  assign out_valid_bytes  = vb_r;
  assign out_block_error  = err_r;

endmodule

// ===== dv/dcfc_checker.sv =====
// Predicts and checks the result words of the DES-CBC file cipher.
// Depends on dcfc_pkg for the DES tables and the register indexes.
`timescale 1ns / 1ps
module dcfc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_data_block,
  input  logic [3:0]  in_byte_count,
  input  logic        in_final_block,
  input  logic        in_start_file,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result_block,
  input  logic [3:0]  out_valid_bytes,
  input  logic        out_block_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import dcfc_pkg::*;

  typedef struct packed {
    logic [63:0] blk;
    logic [3:0]  nbytes;
    logic        err;
  } cipher_word_t;

  cipher_word_t expected_words[$];

  logic [63:0] key_reg;
  logic        keep_parity;
  logic        decrypt_mode;
  logic [63:0] pad_reg;
  logic [63:0] chain;
  logic [47:0] subkeys[16];

  task automatic build_subkeys();
    logic [63:0] k;
    logic [55:0] cd;
    logic [27:0] c, d;
    k = key_reg;
    if (!keep_parity) begin
      for (int i = 0; i < 8; i++) k[8*i+7] = ~^key_reg[8*i +: 7];
    end
    for (int i = 0; i < 56; i++) cd[55-i] = k[64-PC1_T[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < 16; r++) begin
      if (ROT_T[r] == 2'd2) begin
        c = {c[25:0], c[27:26]};
        d = {d[25:0], d[27:26]};
      end else begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) subkeys[r][47-i] = cd[56-PC2_T[i]];
    end
  endtask

  function automatic logic [63:0] des_apply(input logic [63:0] x, input logic dec);
    logic [63:0] t, o;
    logic [31:0] l, r, f, sb;
    logic [47:0] e;
    logic [5:0]  six;
    for (int i = 0; i < 64; i++) t[63-i] = x[64-IP_T[i]];
    l = t[63:32];
    r = t[31:0];
    for (int n = 0; n < 16; n++) begin
      for (int i = 0; i < 48; i++) e[47-i] = r[32-E_T[i]];
      e ^= subkeys[dec ? 15 - n : n];
      for (int s = 0; s < 8; s++) begin
        six = e[47-6*s -: 6];
        sb[31-4*s -: 4] = SBOX_T[s][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) f[31-i] = sb[32-P_T[i]];
      f ^= l;
      l = r;
      r = f;
    end
    t = {r, l};
    for (int i = 0; i < 64; i++) o[63-i] = t[64-FP_T[i]];
    return o;
  endfunction

  // Works out the result of one accepted word and advances the chaining vector, except after a padded encrypt block.
  function automatic cipher_word_t cipher_word(input logic [63:0] data,
                                               input logic [3:0] cnt, input logic fin);
    cipher_word_t w;
    logic [63:0] blk;
    int n;
    w.nbytes = 4'd8;
    w.err = 1'b0;
    if (!decrypt_mode) begin
      if (!fin && cnt >= 8) begin
        w.blk = des_apply(data ^ chain, 1'b0);
        chain = w.blk;
      end else begin
        n = (cnt > 7) ? 7 : cnt;
        for (int i = 0; i < 8; i++) begin
          if (i == 7) blk[7:0] = n[7:0];
          else if (i < n) blk[63-8*i -: 8] = data[63-8*i -: 8];
          else blk[63-8*i -: 8] = pad_reg[63-8*(i-n) -: 8];
        end
        w.blk = des_apply(blk ^ chain, 1'b0);
      end
    end else begin
      w.blk = des_apply(data, 1'b1) ^ chain;
      chain = data;
      if (fin) begin
        if (w.blk[7:0] > 8'd7) begin
          w.err = 1'b1;
          w.nbytes = 4'd0;
        end else begin
          w.nbytes = w.blk[3:0];
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin
    cipher_word_t got, want;
    if (!rst_n) begin
      key_reg      = '0;
      keep_parity  = 1'b0;
      decrypt_mode = 1'b0;
      pad_reg      = '0;
      chain        = '0;
      fail_count   = 0;
      expected_words.delete();
      build_subkeys();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          2'(REG_KEY): begin
            key_reg = cfg_data;
            build_subkeys();
          end
          2'(REG_PARITY): begin
            keep_parity = cfg_data[0];
            build_subkeys();
          end
          2'(REG_DIR): decrypt_mode = cfg_data[0];
          2'(REG_PAD): pad_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_start_file) chain = '0;
        expected_words.push_back(cipher_word(in_data_block, in_byte_count, in_final_block));
      end
      if (out_valid && !out_stall) begin
        got = '{out_result_block, out_valid_bytes, out_block_error};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result word %h bytes %0d err %0b",
                     got.blk, got.nbytes, got.err);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected %h bytes %0d err %0b, got %h bytes %0d err %0b",
                       want.blk, want.nbytes, want.err, got.blk, got.nbytes, got.err);
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the DES-CBC file cipher.
// Depends on dcfc_pkg, the block des_cbc_file_cipher and dcfc_checker.
`timescale 1ns / 1ps
module testbench;
  import dcfc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_data_block;
  logic [3:0]  in_byte_count;
  logic        in_final_block;
  logic        in_start_file;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_block;
  logic [3:0]  out_valid_bytes;
  logic        out_block_error;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending;

  // When set, neither side idles, so words go through back to back.
  bit          no_idle;

  // Flags of each word sent while encrypting, and the ciphertext that came
  // back, so that the decrypt phase can replay the same files.
  logic [1:0]  sent_flags[$];
  logic [63:0] cipher_log[$];

  des_cbc_file_cipher u_dut (.*);

  dcfc_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result words are recorded as they are taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) cipher_log.push_back(out_result_block);
  end

  // Receiver stalls: mostly none or short, occasionally a long one.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    begin out_stall <= 1'b1; stall_left <= $urandom_range(0, 3); end
        2:       begin out_stall <= 1'b1; stall_left <= $urandom_range(15, 40); end
        default: begin out_stall <= 1'b0; stall_left <= $urandom_range(0, 20); end
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (no_idle || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Presents one word and returns at the edge that takes it.
  task automatic send_word(input logic [63:0] data, input logic [3:0] cnt,
                           input logic fin, input logic start);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_block  <= data;
    in_byte_count  <= cnt;
    in_final_block <= fin;
    in_start_file  <= start;
    sent_flags.push_back({fin, start});
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Waits until every expected word has come back, then lets the engine
  // drain for longer than its latency.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One file: full blocks, now and then one with a random byte count, and a final block
  // carrying any byte count the field allows.
  task automatic encrypt_file(input int len);
    logic [3:0] cnt;
    for (int b = 0; b < len; b++) begin
      if (b == len - 1) cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                         : 4'($urandom_range(0, 8));
      else cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      send_word({$urandom, $urandom}, cnt, b == len - 1, b == 0);
    end
  endtask

  logic [63:0] key_pick, pad_pick;
  logic [1:0]  flags;
  int          nwords;

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_block  = '0;
    in_byte_count  = '0;
    in_final_block = 1'b0;
    in_start_file  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    no_idle        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset configuration: data extremes, byte counts
    // 0 to 8 and an oversized count on a final block, a full final block, short
    // and oversized non-final blocks, and a start in the middle of a chain.
    send_word('0, 4'd8, 1'b0, 1'b1);
    send_word('1, 4'd8, 1'b0, 1'b0);
    for (int c = 0; c <= 8; c++) send_word('1, c[3:0], 1'b1, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b0, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 4'd15, 1'b0, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 4'd15, 1'b1, 1'b1);
    send_word('0, 4'd8, 1'b0, 1'b1);
    wait_idle();
    write_reg(2'(REG_DIR), 64'd1);
    send_word('0, 4'd0, 1'b1, 1'b1);
    send_word('1, 4'd8, 1'b0, 1'b0);
    send_word('1, 4'd8, 1'b1, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin key_pick = '0; pad_pick = '1; end
        1:       begin key_pick = '1; pad_pick = '0; end
        default: begin key_pick = {$urandom, $urandom}; pad_pick = {$urandom, $urandom}; end
      endcase
      no_idle = (p == 3);
      write_reg(2'(REG_KEY), key_pick);
      write_reg(2'(REG_PARITY), 64'(p[0]));
      write_reg(2'(REG_PAD), pad_pick);
      write_reg(2'(REG_DIR), 64'd0);
      sent_flags.delete();
      cipher_log.delete();
      nwords = 0;
      while (nwords < 30) begin
        encrypt_file($urandom_range(1, 6));
        nwords = sent_flags.size();
      end
      wait_idle();

      // Replay the ciphertext as files, then some random ciphertext whose
      // final blocks mostly decode to a corrupt count.
      write_reg(2'(REG_DIR), 64'd1);
      nwords = cipher_log.size();
      for (int w = 0; w < nwords; w++) begin
        flags = sent_flags.pop_front();
        send_word(cipher_log.pop_front(), 4'($urandom_range(0, 15)), flags[1], flags[0]);
      end
      for (int k = 0; k < 6; k++)
        send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dcfc_pkg.sv
rtl/core/dcfc_front.sv
rtl/core/dcfc_queue.sv
rtl/core/dcfc_back.sv
rtl/core/des_cbc_file_cipher.sv
dv/dcfc_checker.sv
dv/testbench.sv
